### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define GAR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define GAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GAR_ASSERT(lbl, prop, msg)
`define GAR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### design/gar_pkg.sv
// ----------------------------------------------------------------------------
// gar_pkg
// Shared types and constants of the AR(1)-GARCH(1,1) return step unit.
// ----------------------------------------------------------------------------
package gar_pkg;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_RETURN       = 3'd0,
    CFG_AR_COEFFICIENT    = 3'd1,
    CFG_VARIANCE_CONSTANT = 3'd2,
    CFG_RESIDUAL_WEIGHT   = 3'd3,
    CFG_VARIANCE_WEIGHT   = 3'd4
  } cfg_reg_t;

endpackage

### design/gar_if.sv
// ----------------------------------------------------------------------------
// gar_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface gar_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] shock;
  logic signed [DATA_WIDTH-1:0] volatility_now;
  logic signed [DATA_WIDTH-1:0] return_now;
  logic signed [DATA_WIDTH-1:0] return_before;

  modport source(output valid, shock, volatility_now, return_now, return_before,
                 input ready);
  modport sink(input valid, shock, volatility_now, return_now, return_before,
               output ready);
endinterface

interface gar_out_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] next_return;
  logic        [DATA_WIDTH-2:0] next_volatility;
  logic                         saturated;

  modport source(output valid, next_return, next_volatility, saturated, input ready);
  modport sink(input valid, next_return, next_volatility, saturated, output ready);
endinterface

### design/ar1_garch11_return_step_unit.sv
// ----------------------------------------------------------------------------
// ar1_garch11_return_step_unit
// One AR(1)-GARCH(1,1) return step per item in signed fixed point.
// ----------------------------------------------------------------------------
// Items enter on in_ch (shock, current volatility, current and previous
// return) and results leave on out_ch (next return, next volatility and a
// saturation flag). Both channels use valid/ready; an item moves on an edge
// where both are high. The five model registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no item is in
// flight, as the block itself does not enforce it. The pipeline takes one
// item per cycle while out_ch is not stalled. Five stages form the residual
// and the variance, the square root spends one stage per result bit, and two
// more stages form and register the return.
// The whole pipeline advances together. While a result waits on out_ch and
// out_ch.ready is low, every stage holds and in_ch.ready is low; no item is
// lost or repeated. Reset clears all valid bits and the registers to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ar1_garch11_return_step_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gar_in_if.sink                        in_ch,
  gar_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [gar_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]         cfg_data
);

  import gar_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int EW     = 2 * W + 2;
  localparam int SIDE_W = 2 + W + EW;

  logic signed [W-1:0]   mean_r, ar_r, vc_r, wr_r, wv_r;
  logic                  en;
  logic                  fv;
  logic [2*W-3:0]        rad;
  logic                  vsat, rsat;
  logic signed [W-1:0]   u;
  logic signed [EW-1:0]  rb;
  logic                  sv;
  logic [W-2:0]          root;
  logic [SIDE_W-1:0]     side_i, side_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      ar_r   <= '0;
      vc_r   <= '0;
      wr_r   <= '0;
      wv_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MEAN_RETURN:       mean_r <= cfg_data;
        CFG_AR_COEFFICIENT:    ar_r   <= cfg_data;
        CFG_VARIANCE_CONSTANT: vc_r   <= cfg_data;
        CFG_RESIDUAL_WEIGHT:   wr_r   <= cfg_data;
        CFG_VARIANCE_WEIGHT:   wv_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  gar_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .in_valid         (in_ch.valid),
    .shock            (in_ch.shock),
    .volatility_now   (in_ch.volatility_now),
    .return_now       (in_ch.return_now),
    .return_before    (in_ch.return_before),
    .mean_return      (mean_r),
    .ar_coefficient   (ar_r),
    .variance_constant(vc_r),
    .residual_weight  (wr_r),
    .variance_weight  (wv_r),
    .out_valid        (fv),
    .radicand         (rad),
    .vol_sat          (vsat),
    .res_sat          (rsat),
    .shock_o          (u),
    .ret_base         (rb)
  );

  assign side_i = {vsat, rsat, u, rb};

  gar_sqrt #(.DATA_WIDTH(DATA_WIDTH), .SIDE_W(SIDE_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (fv),
    .radicand (rad),
    .side_i   (side_i),
    .out_valid(sv),
    .root     (root),
    .side_o   (side_o)
  );

  gar_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(sv),
    .root    (root),
    .vol_sat (side_o[SIDE_W-1]),
    .res_sat (side_o[SIDE_W-2]),
    .shock   (side_o[SIDE_W-3 -: W]),
    .ret_base(side_o[EW-1:0]),
    .out_ch  (out_ch)
  );

  `GAR_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_ch.valid, "result valid after reset")
  `GAR_ASSERT(a_stall_blocks_input, (out_ch.valid && !out_ch.ready) |-> !in_ch.ready, "input open during output stall")

endmodule

### design/gar_front.sv
// ----------------------------------------------------------------------------
// gar_front
// Five stages: AR products, clipped residual, squares, weighted squares and
// the variance sum with its clamp, giving the square root radicand.
// ----------------------------------------------------------------------------
module gar_front #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [DATA_WIDTH-1:0]          shock,
  input  logic signed [DATA_WIDTH-1:0]          volatility_now,
  input  logic signed [DATA_WIDTH-1:0]          return_now,
  input  logic signed [DATA_WIDTH-1:0]          return_before,
  input  logic signed [DATA_WIDTH-1:0]          mean_return,
  input  logic signed [DATA_WIDTH-1:0]          ar_coefficient,
  input  logic signed [DATA_WIDTH-1:0]          variance_constant,
  input  logic signed [DATA_WIDTH-1:0]          residual_weight,
  input  logic signed [DATA_WIDTH-1:0]          variance_weight,
  output logic                                  out_valid,
  output logic        [2*DATA_WIDTH-3:0]        radicand,
  output logic                                  vol_sat,
  output logic                                  res_sat,
  output logic signed [DATA_WIDTH-1:0]          shock_o,
  output logic signed [2*DATA_WIDTH+1:0]        ret_base
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PW   = 2 * W;
  localparam int EW   = 2 * W + 2;
  localparam int SQW  = 2 * W - F;
  localparam int WPW  = W + SQW + 1;
  localparam int VW   = WPW + 2;
  localparam int LIM  = 2 * W - 2 - F;

  localparam logic signed [EW-1:0] DMAX_E = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [EW-1:0] DMIN_E = ~DMAX_E;

  logic                  v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [PW-1:0]  pa1_r, pb1_r;
  logic signed [W-1:0]   r1_r, s1_r, u1_r;
  logic signed [EW-1:0]  e_nxt, rb_nxt;
  logic signed [W-1:0]   e2_r, s2_r, u2_r;
  logic                  fe2_r;
  logic signed [EW-1:0]  rb2_r;
  logic        [W:0]     neg_e, neg_s;
  logic        [W-1:0]   mag_e, mag_s;
  logic        [PW-1:0]  sq_e, sq_s;
  logic        [SQW-1:0] sqe3_r, sqs3_r;
  logic                  fe3_r;
  logic signed [W-1:0]   u3_r;
  logic signed [EW-1:0]  rb3_r;
  logic signed [WPW-1:0] pe4_r, ps4_r;
  logic                  fe4_r;
  logic signed [W-1:0]   u4_r;
  logic signed [EW-1:0]  rb4_r;
  logic signed [VW-1:0]  var_nxt;
  logic                  pos, big;
  logic [2*W-3:0]        rad5_r;
  logic                  vs5_r, fe5_r;
  logic signed [W-1:0]   u5_r;
  logic signed [EW-1:0]  rb5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_comb begin
    e_nxt  = EW'(r1_r) - EW'(mean_return) - EW'(pa1_r >>> F);
    rb_nxt = EW'(mean_return) + EW'(pb1_r >>> F);
    neg_e  = -{e2_r[W-1], e2_r};
    neg_s  = -{s2_r[W-1], s2_r};
    mag_e  = e2_r[W-1] ? neg_e[W-1:0] : e2_r;
    mag_s  = s2_r[W-1] ? neg_s[W-1:0] : s2_r;
    sq_e   = mag_e * mag_e;
    sq_s   = mag_s * mag_s;
    var_nxt = VW'(variance_constant) + VW'(pe4_r >>> F) + VW'(ps4_r >>> F);
    pos    = !var_nxt[VW-1] && (var_nxt != '0);
    big    = var_nxt[VW-2:LIM] != '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa1_r <= ar_coefficient * return_before;
      pb1_r <= ar_coefficient * return_now;
      r1_r  <= return_now;
      s1_r  <= volatility_now;
      u1_r  <= shock;

      if (e_nxt > DMAX_E) begin
        e2_r  <= DMAX_E[W-1:0];
        fe2_r <= 1'b1;
      end else if (e_nxt < DMIN_E) begin
        e2_r  <= DMIN_E[W-1:0];
        fe2_r <= 1'b1;
      end else begin
        e2_r  <= e_nxt[W-1:0];
        fe2_r <= 1'b0;
      end
      rb2_r <= rb_nxt;
      s2_r  <= s1_r;
      u2_r  <= u1_r;

      sqe3_r <= sq_e[PW-1:F];
      sqs3_r <= sq_s[PW-1:F];
      fe3_r  <= fe2_r;
      u3_r   <= u2_r;
      rb3_r  <= rb2_r;

      pe4_r <= residual_weight * $signed({1'b0, sqe3_r});
      ps4_r <= variance_weight * $signed({1'b0, sqs3_r});
      fe4_r <= fe3_r;
      u4_r  <= u3_r;
      rb4_r <= rb3_r;

      rad5_r <= (pos && !big) ? {var_nxt[LIM-1:0], {F{1'b0}}} : '0;
      vs5_r  <= pos && big;
      fe5_r  <= fe4_r;
      u5_r   <= u4_r;
      rb5_r  <= rb4_r;
    end
  end

  assign out_valid = v5_r;
  assign radicand  = rad5_r;
  assign vol_sat   = vs5_r;
  assign res_sat   = fe5_r;
  assign shock_o   = u5_r;
  assign ret_base  = rb5_r;

endmodule

### design/gar_sqrt.sv
// ----------------------------------------------------------------------------
// gar_sqrt
// Pipelined restoring square root, one result bit per stage, with a sideband
// word that travels alongside each item.
// ----------------------------------------------------------------------------
module gar_sqrt #(
  parameter int DATA_WIDTH = 32,
  parameter int SIDE_W     = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [2*DATA_WIDTH-3:0] radicand,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    out_valid,
  output logic [DATA_WIDTH-2:0]   root,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int W   = DATA_WIDTH;
  localparam int N   = W - 1;
  localparam int RDW = 2 * W - 2;

  logic              v_r    [N];
  logic [W-1:0]      rem_r  [N];
  logic [W-2:0]      root_r [N];
  logic [RDW-1:0]    rad_r  [N];
  logic [SIDE_W-1:0] side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic              v_in;
    logic [W-1:0]      rem_in;
    logic [W-2:0]      root_in;
    logic [RDW-1:0]    rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [W+1:0]      rem2, trial, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      rem2  = {rem_in, rad_in[RDW-1 -: 2]};
      trial = {1'b0, root_in, 2'b01};
      ge    = rem2 >= trial;
      diff  = rem2 - trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[W-1:0] : rem2[W-1:0];
        root_r[k] <= {root_in[W-3:0], ge};
        rad_r[k]  <= {rad_in[RDW-3:0], 2'b00};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign root      = root_r[N-1];
  assign side_o    = side_r[N-1];

endmodule

### design/gar_back.sv
// ----------------------------------------------------------------------------
// gar_back
// Volatility times shock, the final return sum with clipping, and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module gar_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 28
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic        [DATA_WIDTH-2:0]   root,
  input  logic                           vol_sat,
  input  logic                           res_sat,
  input  logic signed [DATA_WIDTH-1:0]   shock,
  input  logic signed [2*DATA_WIDTH+1:0] ret_base,
  gar_out_if.source                      out_ch
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int EW = 2 * W + 2;
  localparam int RW = EW + 1;

  localparam logic signed [RW-1:0] DMAX_R = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] DMIN_R = ~DMAX_R;

  logic                  va_r, ov_r;
  logic signed [2*W-1:0] pa_r;
  logic signed [EW-1:0]  rba_r;
  logic [W-2:0]          vola_r;
  logic                  fa_r;
  logic [W-2:0]          vol_in;
  logic signed [RW-1:0]  ret_nxt;
  logic signed [W-1:0]   ret_r;
  logic [W-2:0]          vol_r;
  logic                  sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      ov_r <= va_r;
    end
  end

  // A saturated volatility also scales the shock at its clipped value.
  assign vol_in  = vol_sat ? {(W-1){1'b1}} : root;
  assign ret_nxt = RW'(rba_r) + RW'(pa_r >>> F);

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r   <= $signed({1'b0, vol_in}) * shock;
      rba_r  <= ret_base;
      vola_r <= vol_in;
      fa_r   <= vol_sat | res_sat;

      vol_r <= vola_r;
      if (ret_nxt > DMAX_R) begin
        ret_r <= DMAX_R[W-1:0];
        sat_r <= 1'b1;
      end else if (ret_nxt < DMIN_R) begin
        ret_r <= DMIN_R[W-1:0];
        sat_r <= 1'b1;
      end else begin
        ret_r <= ret_nxt[W-1:0];
        sat_r <= fa_r;
      end
    end
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.next_return     = ret_r;
  assign out_ch.next_volatility = vol_r;
  assign out_ch.saturated       = sat_r;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the AR(1)-GARCH(1,1) return step unit.
// ----------------------------------------------------------------------------
// Items are driven from a queue of pending items. A predictor of the
// fixed-point step computes the expected result of every accepted item. The
// monitor compares each result with the oldest expected one. The run moves
// through several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gar_pkg::*;

  localparam int DW = 32;
  localparam int FB = 28;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [DW-1:0] shock;
    logic signed [DW-1:0] volatility_now;
    logic signed [DW-1:0] return_now;
    logic signed [DW-1:0] return_before;
  } step_item_t;

  typedef struct packed {
    logic signed [DW-1:0] next_return;
    logic [DW-2:0]        next_volatility;
    logic                 saturated;
  } step_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;

  gar_in_if #(.DATA_WIDTH(DW)) in_ch ();
  gar_out_if #(.DATA_WIDTH(DW)) out_ch ();

  ar1_garch11_return_step_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  longint mean_ret, ar_coef, var_const, resid_wt, var_wt;
  step_item_t pending_items[$];
  step_result_t expected_results[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit in_fire = 0;

  function automatic longint clip_word(longint x, inout bit flag);
    longint hi, lo;
    hi = (longint'(1) <<< (DW - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (x < lo) begin
      flag = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic longint weighted_square(longint w, longint x);
    longint unsigned m, sq;
    longint hi, lo;
    m = (x < 0) ? longint'(-x) : x;
    sq = (m * m) >> FB;
    hi = longint'(sq >> FB);
    lo = longint'(sq & ((64'd1 << FB) - 1));
    return w * hi + ((w * lo) >>> FB);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic step_result_t predict_step(step_item_t it);
    step_result_t res;
    longint resid, variance, ret;
    longint unsigned vol;
    bit flag;
    flag = 1'b0;
    resid = longint'(it.return_now) - mean_ret
          - ((ar_coef * longint'(it.return_before)) >>> FB);
    resid = clip_word(resid, flag);
    variance = var_const + weighted_square(resid_wt, resid)
             + weighted_square(var_wt, longint'(it.volatility_now));
    if (variance <= 0) begin
      vol = 0;
    end else if (longint'(variance) >= (longint'(1) <<< (2 * (DW - 1) - FB))) begin
      vol = (64'd1 << (DW - 1)) - 1;
      flag = 1'b1;
    end else begin
      vol = floor_sqrt(longint'(variance) << FB);
    end
    ret = mean_ret + ((ar_coef * longint'(it.return_now)) >>> FB)
        + ((longint'(vol) * longint'(it.shock)) >>> FB);
    ret = clip_word(ret, flag);
    res.next_return = ret[DW-1:0];
    res.next_volatility = vol[DW-2:0];
    res.saturated = flag;
    return res;
  endfunction

  function automatic logic [DW-1:0] random_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return 32'($signed($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
      6, 7: return 32'($urandom_range(32'h0400_0000));
      default: return $urandom;
    endcase
  endfunction

  function automatic step_item_t random_item();
    step_item_t it;
    it.shock = random_value();
    it.volatility_now = random_value();
    it.return_now = random_value();
    it.return_before = random_value();
    return it;
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MEAN_RETURN:       mean_ret = longint'($signed(value));
      CFG_AR_COEFFICIENT:    ar_coef = longint'($signed(value));
      CFG_VARIANCE_CONSTANT: var_const = longint'($signed(value));
      CFG_RESIDUAL_WEIGHT:   resid_wt = longint'($signed(value));
      CFG_VARIANCE_WEIGHT:   var_wt = longint'($signed(value));
      default: ;
    endcase
  endtask

  task automatic write_model(logic [DW-1:0] mu, logic [DW-1:0] phi, logic [DW-1:0] omega,
                             logic [DW-1:0] alpha, logic [DW-1:0] beta);
    write_register(CFG_MEAN_RETURN, mu);
    write_register(CFG_AR_COEFFICIENT, phi);
    write_register(CFG_VARIANCE_CONSTANT, omega);
    write_register(CFG_RESIDUAL_WEIGHT, alpha);
    write_register(CFG_VARIANCE_WEIGHT, beta);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    repeat (count) pending_items.push_back(random_item());
  endtask

  // Sender. A new item is offered only once the previous one was accepted.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        {in_ch.shock, in_ch.volatility_now, in_ch.return_now, in_ch.return_before}
          <= pending_items[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= 300;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    step_result_t want;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      expected_results.push_back(predict_step(pending_items.pop_front()));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item at %0t", $realtime);
      end else begin
        want = expected_results.pop_front();
        if (want.next_return !== out_ch.next_return
            || want.next_volatility !== out_ch.next_volatility
            || want.saturated !== out_ch.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected ret %h vol %h sat %b, got ret %h vol %h sat %b",
                     $realtime, want.next_return, want.next_volatility, want.saturated,
                     out_ch.next_return, out_ch.next_volatility, out_ch.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (pending_items.size() == 0 && expected_results.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL ar1_garch11_return_step_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    step_item_t it;
    in_ch.valid = 1'b0;
    in_ch.shock = '0;
    in_ch.volatility_now = '0;
    in_ch.return_now = '0;
    in_ch.return_before = '0;
    out_ch.ready = 1'b0;
    mean_ret = 0;
    ar_coef = 0;
    var_const = 0;
    resid_wt = 0;
    var_wt = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: every variance is zero, so every result is zero.
    send_idle_pct = 36;
    recv_idle_pct = 56;
    queue_random(20);
    drain();

    // Typical model, directed extremes first.
    write_model(32'h0004_1893, 32'h0199_999a, 32'h0001_0000, 32'h0199_999a, 32'h0d99_999a);
    write_register(CFG_UNUSED_IDX, 32'h7fff_ffff);
    for (int k = 0; k < 16; k++) begin
      it.shock = k[0] ? 32'h7fff_ffff : 32'h8000_0000;
      it.volatility_now = k[1] ? 32'h7fff_ffff : 32'h8000_0000;
      it.return_now = k[2] ? 32'h7fff_ffff : 32'h8000_0000;
      it.return_before = k[3] ? 32'h7fff_ffff : 32'h8000_0000;
      pending_items.push_back(it);
    end
    it = '0;
    pending_items.push_back(it);
    it.shock = 32'h1000_0000;
    it.volatility_now = 32'h0100_0000;
    pending_items.push_back(it);
    queue_random(200);
    hold_request = 1'b1;
    queue_random(100);
    drain();

    // Negative variance constant, so the variance often clamps to zero.
    write_model(32'hf000_0000, 32'hf000_0000, 32'hf000_0000, 32'h0100_0000, 32'h0100_0000);
    queue_random(150);
    drain();

    // Largest register values.
    send_idle_pct = 56;
    recv_idle_pct = 36;
    write_model(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_random(120);
    drain();

    // Smallest register values.
    write_model(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_random(120);
    drain();

    // Random registers.
    write_model($urandom, $urandom, $urandom, $urandom, $urandom);
    queue_random(150);
    hold_request = 1'b1;
    drain();

    // Plain GARCH(1,1), no idling.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_model(32'h0, 32'h0, 32'h0000_8000, 32'h0133_3333, 32'h0e66_6666);
    queue_random(270);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS ar1_garch11_return_step_unit");
    end else begin
      $display("FAIL ar1_garch11_return_step_unit");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/gar_pkg.sv
design/gar_if.sv
design/gar_front.sv
design/gar_sqrt.sv
design/gar_back.sv
design/ar1_garch11_return_step_unit.sv
sim/tb_top.sv
